[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pic check failed: same-cycle implication");

// Next-cycle implication.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pic check failed: next-cycle implication");

`endif

[src/pic_pkg.sv]
// ----------------------------------------------------------------------------
// pic_pkg
// Shared constants, types and saturation helper of the PI controller.
// ----------------------------------------------------------------------------
package pic_pkg;

  localparam int FRAC_BITS       = 12;
  // must be a power of two: the error normalization is a shift
  localparam int COUNTS_PER_UNIT = 4096;
  localparam int CPU_LOG2        = $clog2(COUNTS_PER_UNIT);
  localparam int INT_W           = FRAC_BITS + 2;
  localparam int LIMIT           = 1 << FRAC_BITS;
  // count difference shifted up into Q format, with headroom
  localparam int SCL_W           = 18 + FRAC_BITS;
  localparam int WIDE_W          = 66;
  localparam int ADDR_W          = 4;
  localparam int DATA_W          = 32;

  typedef logic signed [31:0] s32_t;
  typedef logic signed [63:0] s64_t;
  typedef logic signed [15:0] s16_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef enum logic [1:0] {
    REG_KP   = 2'd0,
    REG_KI   = 2'd1,
    REG_DMAX = 2'd2,
    REG_DMIN = 2'd3
  } reg_idx_t;

  typedef struct packed {
    s32_t kp;
    s32_t ki;
    s16_t dmax;
    s16_t dmin;
  } pic_cfg_t;

  // Clamp a wide signed value into the 32-bit signed range.
  function automatic s32_t sat32(input wide_t x);
    s32_t res;
    if (x[WIDE_W-1:31] == '0 || x[WIDE_W-1:31] == '1) begin
      res = x[31:0];
    end else if (x[WIDE_W-1]) begin
      res = 32'sh8000_0000;
    end else begin
      res = 32'sh7FFF_FFFF;
    end
    return res;
  endfunction

endpackage

[src/pi_controller_q12.sv]
// ----------------------------------------------------------------------------
// pi_controller_q12
// Fixed-point PI controller with integral anti-windup and clamped drive.
// ----------------------------------------------------------------------------
// After a word is accepted the sequencer steps through MUL_P, MUL_I, ACC,
//   SUM, MUL_D and FIN, making three passes through the single shared
//   multiplier; out_valid rises once FIN hands on the result.
// in_ready is low while a word is in flight; a finished result that is not
//   taken holds the last step until the output register frees up.
// Reset (synchronous, rst_n low): sequencer idle, integral and out_valid zero.
// ----------------------------------------------------------------------------
module pi_controller_q12 (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [15:0]               in_target,
  input  logic [15:0]               in_measured,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [15:0]        out_drive,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pic_pkg::ADDR_W-1:0] paddr,
  input  logic [pic_pkg::DATA_W-1:0] pwdata,
  output logic [pic_pkg::DATA_W-1:0] prdata,
  output logic                      pready
);
  import pic_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_I,
    ST_ACC,
    ST_SUM,
    ST_MUL_D,
    ST_FIN
  } state_t;

  state_t               state_r, state_nxt;
  s32_t                 err_r, err_nxt;
  s32_t                 p_r, p_nxt;
  s32_t                 u_r, u_nxt;
  logic signed [INT_W-1:0] integral_r, integral_nxt;
  logic                 out_valid_r, out_valid_nxt;
  s16_t                 out_drive_r, out_drive_nxt;

  pic_cfg_t             cfg;
  s32_t                 op_a, op_b;
  logic                 mul_en;
  s64_t                 prod;
  s32_t                 sat_out;

  logic signed [16:0]   diff;
  logic signed [SCL_W-1:0] scaled, biased, quot;
  logic signed [16:0]   span;
  logic signed [32:0]   acc_sum, acc_clip;
  logic signed [32:0]   drv_sum, drv_hi, drv_lo;
  logic                 in_acc;
  logic                 out_free;

  pic_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pic_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  pic_sat u_sat (
    .prod (prod),
    .res  (sat_out)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;
  assign out_free  = !out_valid_r || out_ready;

  // Normalize the error: counts shifted up to Q format, then divided by the
  // unit scale with truncation toward zero (bias negatives before shifting).
  assign diff   = 17'(signed'({1'b0, in_target})) - 17'(signed'({1'b0, in_measured}));
  assign scaled = SCL_W'(diff) <<< FRAC_BITS;
  assign biased = scaled + (scaled[SCL_W-1] ? SCL_W'(COUNTS_PER_UNIT - 1) : SCL_W'(0));
  assign quot   = biased >>> CPU_LOG2;

  assign span = 17'(cfg.dmax) - 17'(cfg.dmin);

  // Route operands into the shared multiplier for the current step.
  always_comb begin
    mul_en = 1'b0;
    op_a   = cfg.kp;
    op_b   = err_r;
    case (state_r)
      ST_MUL_P: begin
        mul_en = 1'b1;
      end
      ST_MUL_I: begin
        mul_en = 1'b1;
        op_a   = cfg.ki;
      end
      ST_MUL_D: begin
        mul_en = 1'b1;
        op_a   = u_r;
        op_b   = 32'(span);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Anti-windup: add the increment and clamp to plus or minus one unit.
  always_comb begin
    acc_sum = 33'(sat_out) + 33'(integral_r);
    if (acc_sum > 33'(LIMIT)) begin
      acc_clip = 33'(LIMIT);
    end else if (acc_sum < -33'(LIMIT)) begin
      acc_clip = -33'(LIMIT);
    end else begin
      acc_clip = acc_sum;
    end
  end

  // Offset by the lower limit, then clamp against max first and min last,
  // so inverted limits leave the drive at min.
  always_comb begin
    drv_sum = 33'(sat_out) + 33'(cfg.dmin);
    drv_hi  = (drv_sum > 33'(cfg.dmax)) ? 33'(cfg.dmax) : drv_sum;
    drv_lo  = (drv_hi < 33'(cfg.dmin)) ? 33'(cfg.dmin) : drv_hi;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    err_nxt       = err_r;
    p_nxt         = p_r;
    u_nxt         = u_r;
    integral_nxt  = integral_r;
    out_valid_nxt = out_valid_r;
    out_drive_nxt = out_drive_r;

    // drop the result once the consumer takes it
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          err_nxt   = sat32(WIDE_W'(quot));
          state_nxt = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        state_nxt = ST_MUL_I;
      end
      ST_MUL_I: begin
        // proportional product is ready at the rescale unit
        p_nxt     = sat_out;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        integral_nxt = INT_W'(acc_clip);
        state_nxt    = ST_SUM;
      end
      ST_SUM: begin
        u_nxt     = sat32(WIDE_W'(p_r) + WIDE_W'(integral_r));
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // hold here until the output register is free
        if (out_free) begin
          out_drive_nxt = drv_lo[15:0];
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      integral_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      integral_r  <= integral_nxt;
      out_valid_r <= out_valid_nxt;
    end
    err_r       <= err_nxt;
    p_r         <= p_nxt;
    u_r         <= u_nxt;
    out_drive_r <= out_drive_nxt;
  end

endmodule

[src/pic_regs.sv]
// ----------------------------------------------------------------------------
// pic_regs
// APB-style configuration registers: gains and drive limits.
// ----------------------------------------------------------------------------
module pic_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pic_pkg::ADDR_W-1:0] paddr,
  input  logic [pic_pkg::DATA_W-1:0] pwdata,
  output logic [pic_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output pic_pkg::pic_cfg_t         cfg
);
  import pic_pkg::*;

  pic_cfg_t cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_KP:   cfg_r.kp   <= pwdata;
        REG_KI:   cfg_r.ki   <= pwdata;
        REG_DMAX: cfg_r.dmax <= pwdata[15:0];
        REG_DMIN: cfg_r.dmin <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_KP:   prdata = cfg_r.kp;
      REG_KI:   prdata = cfg_r.ki;
      REG_DMAX: prdata = DATA_W'(cfg_r.dmax);
      REG_DMIN: prdata = DATA_W'(cfg_r.dmin);
    endcase
  end

endmodule

[src/pic_mul.sv]
// ----------------------------------------------------------------------------
// pic_mul
// Shared 32x32 signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module pic_mul (
  input  logic          clk,
  input  logic          en,
  input  pic_pkg::s32_t op_a,
  input  pic_pkg::s32_t op_b,
  output pic_pkg::s64_t prod
);
  import pic_pkg::*;

  s64_t prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= s64_t'(op_a) * s64_t'(op_b);
    end
  end

  assign prod = prod_r;

endmodule

[src/pic_sat.sv]
// ----------------------------------------------------------------------------
// pic_sat
// Rescale a product back to Q format and saturate it to 32 bits.
// ----------------------------------------------------------------------------
module pic_sat (
  input  pic_pkg::s64_t prod,
  output pic_pkg::s32_t res
);
  import pic_pkg::*;

  s64_t shifted;

  // arithmetic shift rounds toward minus infinity
  assign shifted = prod >>> FRAC_BITS;
  assign res     = sat32(WIDE_W'(shifted));

endmodule

[src/pic_checker.sv]
// ----------------------------------------------------------------------------
// pic_checker
// Port-level checks on the PI controller handshakes and sequencing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pic_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_drive
);

  // a stalled result word holds its value
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_drive))

  // the block goes busy right after taking a word
  `CHK_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // still busy mid-computation
  `CHK_NEXT(a_busy_mid, clk, rst_n, in_valid && in_ready, ##2 !in_ready)

  // a new result only appears at the end of a busy period
  `CHK_IMPL(a_result_from_busy, clk, rst_n, $rose(out_valid), $past(!in_ready))

endmodule

bind pi_controller_q12 pic_checker u_pic_checker (.*);

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pi_controller_q12. It writes the gains and the
// drive limits over the APB port, streams setpoint and measurement words
// through the valid/ready input, and checks every drive word that comes out
// against a cycle-free model of the controller, including the integral.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pic_pkg::*;

  localparam int SEGMENTS     = 8;
  localparam int WORDS_PER_SEG = 175;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [15:0] target;
    logic [15:0] measured;
  } sample_t;

  // Clock and reset.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // DUT ports. Every input starts at a known value.
  logic                     in_valid    = 1'b0;
  logic                     in_ready;
  logic [15:0]              in_target   = '0;
  logic [15:0]              in_measured = '0;
  logic                     out_valid;
  logic                     out_ready   = 1'b0;
  logic signed [15:0]       out_drive;
  logic                     psel        = 1'b0;
  logic                     penable     = 1'b0;
  logic                     pwrite      = 1'b0;
  logic [ADDR_W-1:0]        paddr       = '0;
  logic [DATA_W-1:0]        pwdata      = '0;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  pi_controller_q12 DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_target   (in_target),
    .in_measured (in_measured),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_drive   (out_drive),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Words waiting to be offered, and drive values waiting to come out.
  sample_t            sample_q[$];
  logic signed [15:0] drive_q[$];

  // Words queued so far and drive words checked so far.
  int unsigned queued_count  = 0;
  int unsigned checked_count = 0;

  // Idle rates for the current phase, in percent.
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;

  // Toggling this asks the receiver process for one long hold-off.
  logic hold_trig = 1'b0;

  int unsigned mismatch_count = 0;

  // Shadow copy of the controller: registers and the integral accumulator.
  longint kp_sh    = 0;
  longint ki_sh    = 0;
  longint dmax_sh  = 0;
  longint dmin_sh  = 0;
  longint integ_sh = 0;

  task automatic note_mismatch(string what, int got, int want);
    $display("%0t ns: mismatch (%s): got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Clamp to the signed 32-bit range; every wide intermediate saturates.
  function automatic longint clip_s32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Advance the shadow integral by one sample and return the drive it gives.
  function automatic logic signed [15:0] pi_drive(logic [15:0] tgt, logic [15:0] meas);
    longint err, p_term, incr, acc, u, span, drv;
    err    = clip_s32(((longint'(tgt) - longint'(meas)) * LIMIT) / COUNTS_PER_UNIT);
    p_term = clip_s32((kp_sh * err) >>> FRAC_BITS);
    incr   = clip_s32((ki_sh * err) >>> FRAC_BITS);
    // anti-windup: hold the integral within plus or minus one per unit
    acc = integ_sh + incr;
    if (acc > LIMIT) acc = LIMIT;
    if (acc < -LIMIT) acc = -LIMIT;
    integ_sh = acc;
    u    = clip_s32(p_term + acc);
    span = dmax_sh - dmin_sh;
    drv  = clip_s32((u * span) >>> FRAC_BITS) + dmin_sh;
    // upper clamp first, lower clamp last: inverted limits leave drive_min
    if (drv > dmax_sh) drv = dmax_sh;
    if (drv < dmin_sh) drv = dmin_sh;
    return drv[15:0];
  endfunction

  // Driver: offer queued words, hold each until the handshake takes it.
  always @(posedge clk) begin : drive_words
    sample_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // predict at the edge that accepts the word, in acceptance order
      if (in_valid && in_ready) begin
        drive_q.push_back(pi_drive(in_target, in_measured));
      end
      // payload may change only when nothing is on offer or it was just taken
      if (!in_valid || in_ready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          w = sample_q.pop_front();
          in_valid    <= 1'b1;
          in_target   <= w.target;
          in_measured <= w.measured;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off counted here on request.
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_seen <= hold_trig;
    end else if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: compare every accepted drive word with the oldest prediction.
  always @(posedge clk) begin : check_drive
    logic signed [15:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (drive_q.size() == 0) begin
        note_mismatch("drive word with none predicted", out_drive, 0);
      end else begin
        want = drive_q.pop_front();
        checked_count++;
        if (out_drive !== want) note_mismatch("drive", out_drive, want);
      end
    end
  end

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_KP:   kp_sh   = longint'($signed(value));
      REG_KI:   ki_sh   = longint'($signed(value));
      REG_DMAX: dmax_sh = longint'($signed(value[15:0]));
      REG_DMIN: dmin_sh = longint'($signed(value[15:0]));
      default:  ;
    endcase
  endtask

  task automatic set_gains(logic [31:0] kp, logic [31:0] ki, int dmax, int dmin);
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_DMAX, 32'(dmax));
    write_reg(REG_DMIN, 32'(dmin));
  endtask

  task automatic queue_word(int tgt, int meas);
    sample_t w;
    w.target   = tgt[15:0];
    w.measured = meas[15:0];
    sample_q.push_back(w);
    queued_count++;
  endtask

  // Mostly small errors around a random setpoint, so the integral walks
  // instead of pinning; the rest is full-range noise, rail values and zero error.
  task automatic queue_random_word();
    int tgt, meas;
    tgt = $urandom_range(65535);
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        meas = tgt + $urandom_range(512) - 256;
        if (meas < 0) meas = 0;
        if (meas > 65535) meas = 65535;
      end
      6, 7: meas = $urandom_range(65535);
      8: begin
        tgt  = $urandom_range(1) ? 65535 : 0;
        meas = $urandom_range(1) ? 65535 : 0;
      end
      default: meas = tgt;
    endcase
    queue_word(tgt, meas);
  endtask

  // Wait until every queued word has come out and been checked.
  task automatic drain();
    while (checked_count != queued_count) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Stimulus: one gain/limit setting and one idle mode per segment.
  initial begin : stimulus
    int lo, hi, t;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      // registers change only with the pipe empty
      case (seg)
        0: set_gains(32'd4096, 32'd64, 2000, -2000);
        // rails on every field: wide intermediates saturate
        1: set_gains(32'h7FFF_FFFF, 32'h8000_0000, 32767, -32768);
        // inverted limits: drive pins to drive_min
        2: set_gains(32'h8000_0000, 32'h7FFF_FFFF, -32768, 32767);
        // zero span
        3: set_gains(32'(int'($urandom_range(16384))), 32'(int'($urandom_range(256))),
                     1234, 1234);
        6: set_gains($urandom, $urandom, int'($urandom_range(32767)),
                     -int'($urandom_range(32768)));
        default: begin
          lo = int'($urandom_range(65535)) - 32768;
          hi = int'($urandom_range(65535)) - 32768;
          if (lo > hi) begin
            t = lo; lo = hi; hi = t;
          end
          set_gains(32'(int'($urandom_range(1 << 17)) - (1 << 16)),
                    32'(int'($urandom_range(1 << 11)) - (1 << 10)), hi, lo);
        end
      endcase

      case (seg % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin sender_idle_pct = 25; recv_stall_pct = 25; end
      endcase

      if (seg == 0) begin
        // field extremes and signed rounding of small negative errors
        queue_word(0, 0);
        queue_word(65535, 0);
        queue_word(0, 65535);
        queue_word(65535, 65535);
        queue_word(1, 0);
        queue_word(0, 1);
        queue_word(32768, 32767);
        queue_word(32767, 32768);
        // push the integral into its upper clamp, hold it, then swing down
        repeat (6) queue_word(65535, 0);
        repeat (10) queue_word(0, 65535);
        queue_word(40000, 40003);
      end else if (seg == 1 || seg == 2) begin
        queue_word(65535, 0);
        queue_word(0, 65535);
        queue_word(0, 0);
      end

      for (int i = 0; i < WORDS_PER_SEG; i++) queue_random_word();

      if (seg == 0) begin
        // stall the output long enough for the block to fill and block input
        @(posedge clk);
        hold_trig <= ~hold_trig;
      end

      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && drive_q.size() == 0) begin
      $display("PASS pi_controller_q12");
    end else begin
      $display("FAIL pi_controller_q12");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("FAIL pi_controller_q12");
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/pic_pkg.sv
src/pic_regs.sv
src/pic_mul.sv
src/pic_sat.sv
src/pi_controller_q12.sv
src/pic_checker.sv
sim/tb.sv
